// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every enabled clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpd_pkg
// Shared types, framing constants and the CRC-16 byte step of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpd_pkg;

    localparam logic [7:0]  START_SHORT = 8'h02;
    localparam logic [7:0]  START_LONG  = 8'h03;
    localparam logic [7:0]  STOP_BYTE   = 8'h03;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // frame status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_CRC_FAIL = 2'd2;
    localparam logic [1:0] ST_END_FAIL = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_VALUES_OPCODE = 8'd0;
    localparam logic [7:0] CFG_SEL_OPCODE    = 8'd1;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] frame_length;
        logic [7:0]  command_byte;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic        values_reply;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [31:0] ok_count;
        logic [31:0] crc_fail_count;
        logic [31:0] end_fail_count;
        logic [31:0] values_ok_count;
    } t_result;

    // CRC-16/XMODEM, MSB first, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ccpd_rx_fsm.sv =====
// ----------------------------------------------------------------------------
// ccpd_rx_fsm
// Frame parser: phase tracking, running CRC, frame fields and counters.
// Produces the result of the current byte combinationally; state advances
// on i_step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpd_rx_fsm #(
    parameter int unsigned MAX_PAYLOAD = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_values_opcode,
    input  logic [7:0]         i_sel_opcode,
    output ccpd_pkg::t_result  o_result
);

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_SHORT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_STOP
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [15:0] r_len,        n_len;
    logic [15:0] r_idx,        n_idx;
    logic [15:0] r_crc,        n_crc;
    logic [15:0] r_frame_crc,  n_frame_crc;
    logic [7:0]  r_first,      n_first;
    logic [31:0] r_ok_cnt,     n_ok_cnt;
    logic [31:0] r_crc_cnt,    n_crc_cnt;
    logic [31:0] r_end_cnt,    n_end_cnt;
    logic [31:0] r_val_cnt,    n_val_cnt;
    logic [15:0] w_len_lo;

    assign w_len_lo = r_len | {8'h00, i_rx_byte};

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_frame_crc = r_frame_crc;
        n_first     = r_first;
        n_ok_cnt    = r_ok_cnt;
        n_crc_cnt   = r_crc_cnt;
        n_end_cnt   = r_end_cnt;
        n_val_cnt   = r_val_cnt;
        o_result    = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == ccpd_pkg::START_SHORT) begin
                    n_phase = PH_LEN_SHORT;
                end else if (i_rx_byte == ccpd_pkg::START_LONG) begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_SHORT: begin
                n_len   = {8'h00, i_rx_byte};
                n_idx   = '0;
                n_crc   = '0;
                n_phase = (i_rx_byte != 8'h00 && {8'h00, i_rx_byte} <= MaxLen)
                          ? PH_PAYLOAD : PH_IDLE;
            end
            PH_LEN_HI: begin
                n_len   = {i_rx_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = w_len_lo;
                n_idx   = '0;
                n_crc   = '0;
                n_phase = (w_len_lo != 16'h0000 && w_len_lo <= MaxLen) ? PH_PAYLOAD : PH_IDLE;
            end
            PH_PAYLOAD: begin
                if (r_idx == 16'h0000) begin
                    n_first = i_rx_byte;
                end
                n_crc = ccpd_pkg::crc16_step(r_crc, i_rx_byte);
                n_idx = r_idx + 16'd1;
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_rx_byte;
                if (n_idx >= r_len) begin
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                n_frame_crc = {i_rx_byte, 8'h00};
                n_phase     = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_frame_crc = r_frame_crc | {8'h00, i_rx_byte};
                n_phase     = PH_STOP;
            end
            default: begin
                o_result.frame_length = r_len;
                o_result.command_byte = r_first;
                o_result.computed_crc = r_crc;
                o_result.received_crc = r_frame_crc;
                // stop byte is checked ahead of the CRC
                if (i_rx_byte != ccpd_pkg::STOP_BYTE) begin
                    o_result.frame_status = ccpd_pkg::ST_END_FAIL;
                    n_end_cnt = r_end_cnt + 32'd1;
                end else if (r_crc == r_frame_crc) begin
                    o_result.frame_status = ccpd_pkg::ST_OK;
                    n_ok_cnt = r_ok_cnt + 32'd1;
                    if (r_first == i_values_opcode || r_first == i_sel_opcode) begin
                        o_result.values_reply = 1'b1;
                        n_val_cnt = r_val_cnt + 32'd1;
                    end
                end else begin
                    o_result.frame_status = ccpd_pkg::ST_CRC_FAIL;
                    n_crc_cnt = r_crc_cnt + 32'd1;
                end
                n_phase = PH_IDLE;
            end
        endcase

        o_result.ok_count        = n_ok_cnt;
        o_result.crc_fail_count  = n_crc_cnt;
        o_result.end_fail_count  = n_end_cnt;
        o_result.values_ok_count = n_val_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_frame_crc <= '0;
            r_first     <= '0;
            r_ok_cnt    <= '0;
            r_crc_cnt   <= '0;
            r_end_cnt   <= '0;
            r_val_cnt   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_frame_crc <= n_frame_crc;
            r_first     <= n_first;
            r_ok_cnt    <= n_ok_cnt;
            r_crc_cnt   <= n_crc_cnt;
            r_end_cnt   <= n_end_cnt;
            r_val_cnt   <= n_val_cnt;
        end
    end

endmodule

// ===== rtl/core/crc_checked_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer
// Byte-stream deframer with CRC-16 check, telemetry reply match and counters.
//
//   channel   direction  handshake               payload
//   rx        in         i_rx_valid/o_rx_ready   i_rx_byte
//   result    out        o_res_valid/i_res_ready o_frame_status .. o_values_ok_count
//   cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One result beat per rx beat, one per cycle unless the result side stalls;
// o_res_valid rises the cycle after rx acceptance, from the single result register.
// rx is taken while the result register is empty or being drained, so a
// stalled result holds rx off for as long as the result beat waits.
// Synchronous reset clears parser state and counters and sets the opcodes to
// 4 and 50; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_checked_packet_deframer #(
    parameter int unsigned MAX_PAYLOAD = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_frame_length,
    output logic [7:0]  o_command_byte,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_received_crc,
    output logic        o_values_reply,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_ok_count,
    output logic [31:0] o_crc_fail_count,
    output logic [31:0] o_end_fail_count,
    output logic [31:0] o_values_ok_count
);

    logic              r_res_valid;
    ccpd_pkg::t_result r_res;
    ccpd_pkg::t_result w_result;
    logic [7:0]        r_values_opcode;
    logic [7:0]        r_sel_opcode;
    logic              w_rx_accept;

    assign o_rx_ready  = !r_res_valid || i_res_ready;
    assign o_cfg_ready = 1'b1;
    assign w_rx_accept = i_rx_valid && o_rx_ready;

    ccpd_rx_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_rx_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_rx_accept),
        .i_rx_byte       (i_rx_byte),
        .i_values_opcode (r_values_opcode),
        .i_sel_opcode    (r_sel_opcode),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_values_opcode <= 8'd4;
            r_sel_opcode    <= 8'd50;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ccpd_pkg::CFG_VALUES_OPCODE) begin
                r_values_opcode <= i_cfg_data;
            end else if (i_cfg_index == ccpd_pkg::CFG_SEL_OPCODE) begin
                r_sel_opcode <= i_cfg_data;
            end
        end
    end

    // result register: load on rx beat, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_rx_accept) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_accept) begin
            r_res <= w_result;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_frame_status    = r_res.frame_status;
    assign o_frame_length    = r_res.frame_length;
    assign o_command_byte    = r_res.command_byte;
    assign o_computed_crc    = r_res.computed_crc;
    assign o_received_crc    = r_res.received_crc;
    assign o_values_reply    = r_res.values_reply;
    assign o_payload_valid   = r_res.payload_valid;
    assign o_payload_byte    = r_res.payload_byte;
    assign o_ok_count        = r_res.ok_count;
    assign o_crc_fail_count  = r_res.crc_fail_count;
    assign o_end_fail_count  = r_res.end_fail_count;
    assign o_values_ok_count = r_res.values_ok_count;

    `ASSERT_NEXT(a_rx_gives_result, w_rx_accept, o_res_valid, "rx beat produced no result")
    `ASSERT_ALWAYS(a_payload_not_end, !(o_res_valid && o_payload_valid && o_frame_status != ccpd_pkg::ST_NONE), "payload beat flagged as frame end")
    `ASSERT_ALWAYS(a_reply_needs_ok, !(o_res_valid && o_values_reply && o_frame_status != ccpd_pkg::ST_OK), "values reply on a failed frame")
    `ASSERT_ALWAYS(a_no_end_fields_zero, !(o_res_valid && o_frame_status == ccpd_pkg::ST_NONE && (o_frame_length != 16'h0000 || o_computed_crc != 16'h0000)), "frame fields set without frame end")

endmodule

// ===== tb/ccpd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpd_tb_pkg
// Predictor and result checker for the packet deframer testbench. Each
// accepted rx beat is run through a software copy of the parser, and the
// predicted result beat waits in a queue until the block returns its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpd_tb_pkg;

    import ccpd_pkg::*;

    localparam int unsigned MAX_LEN = 512;

    typedef enum logic [2:0] {
        SEEK_START,
        SHORT_LEN,
        LONG_LEN_HI,
        LONG_LEN_LO,
        BODY,
        CHECK_HI,
        CHECK_LO,
        END_BYTE
    } parse_state_e;

    typedef enum {FLAW_NONE, FLAW_CRC, FLAW_STOP} frame_flaw_e;

    // CRC-16, poly 0x1021, init 0, fed one data bit at a time, MSB first
    function automatic logic [15:0] crc16_bitwise(input logic [15:0] acc,
                                                  input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ data[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    class deframer_shadow;
        logic [7:0]   full_opcode;
        logic [7:0]   sel_opcode;
        parse_state_e state;
        logic [15:0]  body_len;
        logic [15:0]  body_seen;
        logic [15:0]  crc_acc;
        logic [15:0]  crc_carried;
        logic [7:0]   lead_byte;
        logic [31:0]  n_ok;
        logic [31:0]  n_crc_bad;
        logic [31:0]  n_stop_bad;
        logic [31:0]  n_values;
        t_result      byte_reports[$];
        int           mismatches;
        int           beats_checked;

        function new();
            full_opcode   = 8'd4;
            sel_opcode    = 8'd50;
            state         = SEEK_START;
            body_len      = '0;
            body_seen     = '0;
            crc_acc       = '0;
            crc_carried   = '0;
            lead_byte     = '0;
            n_ok          = '0;
            n_crc_bad     = '0;
            n_stop_bad    = '0;
            n_values      = '0;
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        function void set_register(input logic [7:0] idx, input logic [7:0] val);
            if (idx == CFG_VALUES_OPCODE) begin
                full_opcode = val;
            end else if (idx == CFG_SEL_OPCODE) begin
                sel_opcode = val;
            end
        endfunction

        function int pending();
            return byte_reports.size();
        endfunction

        // Advance the parser by one rx beat and queue the result it causes.
        // Returns 0 for a byte that idle line noise leaves without effect.
        function bit take_byte(input logic [7:0] b);
            t_result r;
            bit      engaged;
            r       = '0;
            engaged = (state != SEEK_START) || b == START_SHORT || b == START_LONG;
            case (state)
                SEEK_START: begin
                    if (b == START_SHORT) begin
                        state = SHORT_LEN;
                    end else if (b == START_LONG) begin
                        state = LONG_LEN_HI;
                    end
                end
                SHORT_LEN: begin
                    body_len  = {8'h00, b};
                    body_seen = '0;
                    crc_acc   = '0;
                    state     = (body_len != 0 && body_len <= MAX_LEN) ? BODY : SEEK_START;
                end
                LONG_LEN_HI: begin
                    body_len = {b, 8'h00};
                    state    = LONG_LEN_LO;
                end
                LONG_LEN_LO: begin
                    body_len  = {body_len[15:8], b};
                    body_seen = '0;
                    crc_acc   = '0;
                    state     = (body_len != 0 && body_len <= MAX_LEN) ? BODY : SEEK_START;
                end
                BODY: begin
                    if (body_seen == 0) begin
                        lead_byte = b;
                    end
                    crc_acc         = crc16_bitwise(crc_acc, b);
                    body_seen       = body_seen + 16'd1;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    if (body_seen >= body_len) begin
                        state = CHECK_HI;
                    end
                end
                CHECK_HI: begin
                    crc_carried = {b, 8'h00};
                    state       = CHECK_LO;
                end
                CHECK_LO: begin
                    crc_carried = {crc_carried[15:8], b};
                    state       = END_BYTE;
                end
                default: begin
                    r.frame_length = body_len;
                    r.command_byte = lead_byte;
                    r.computed_crc = crc_acc;
                    r.received_crc = crc_carried;
                    // stop byte is judged before the CRC
                    if (b != STOP_BYTE) begin
                        r.frame_status = ST_END_FAIL;
                        n_stop_bad++;
                    end else if (crc_acc == crc_carried) begin
                        r.frame_status = ST_OK;
                        n_ok++;
                        if (lead_byte == full_opcode || lead_byte == sel_opcode) begin
                            r.values_reply = 1'b1;
                            n_values++;
                        end
                    end else begin
                        r.frame_status = ST_CRC_FAIL;
                        n_crc_bad++;
                    end
                    state = SEEK_START;
                end
            endcase
            r.ok_count        = n_ok;
            r.crc_fail_count  = n_crc_bad;
            r.end_fail_count  = n_stop_bad;
            r.values_ok_count = n_values;
            byte_reports.push_back(r);
            return engaged;
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            $display("mismatch at result beat %0d: %s", beats_checked, what);
        endtask

        task cmp(input string field, input logic [31:0] got, input logic [31:0] want);
            if (got !== want) begin
                flag_mismatch($sformatf("%s got %0h want %0h", field, got, want));
            end
        endtask

        task check_report(input t_result got);
            t_result want;
            if (byte_reports.size() == 0) begin
                flag_mismatch("result beat with no rx beat pending");
            end else begin
                want = byte_reports.pop_front();
                cmp("frame_status",    32'(got.frame_status),  32'(want.frame_status));
                cmp("frame_length",    32'(got.frame_length),  32'(want.frame_length));
                cmp("command_byte",    32'(got.command_byte),  32'(want.command_byte));
                cmp("computed_crc",    32'(got.computed_crc),  32'(want.computed_crc));
                cmp("received_crc",    32'(got.received_crc),  32'(want.received_crc));
                cmp("values_reply",    32'(got.values_reply),  32'(want.values_reply));
                cmp("payload_valid",   32'(got.payload_valid), 32'(want.payload_valid));
                cmp("payload_byte",    32'(got.payload_byte),  32'(want.payload_byte));
                cmp("ok_count",        got.ok_count,        want.ok_count);
                cmp("crc_fail_count",  got.crc_fail_count,  want.crc_fail_count);
                cmp("end_fail_count",  got.end_fail_count,  want.end_fail_count);
                cmp("values_ok_count", got.values_ok_count, want.values_ok_count);
            end
            beats_checked++;
        endtask
    endclass

endpackage

// ===== tb/tb_crc_checked_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_crc_checked_packet_deframer
// Drives byte streams of good frames, CRC and stop byte errors, rejected
// lengths and line noise into the deframer under four flow control phases,
// reprograms the opcode registers between phases and checks every result
// beat against the predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_crc_checked_packet_deframer;

    import ccpd_pkg::*;
    import ccpd_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [1:0]  o_frame_status;
    logic [15:0] o_frame_length;
    logic [7:0]  o_command_byte;
    logic [15:0] o_computed_crc;
    logic [15:0] o_received_crc;
    logic        o_values_reply;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_ok_count;
    logic [31:0] o_crc_fail_count;
    logic [31:0] o_end_fail_count;
    logic [31:0] o_values_ok_count;

    t_result        seen;
    deframer_shadow shadow;
    int             send_idle;
    int             res_stall;
    int             bytes_sent;
    logic [7:0]     op_full;
    logic [7:0]     op_sel;

    crc_checked_packet_deframer #(
        .MAX_PAYLOAD (MAX_LEN)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_frame_status    (o_frame_status),
        .o_frame_length    (o_frame_length),
        .o_command_byte    (o_command_byte),
        .o_computed_crc    (o_computed_crc),
        .o_received_crc    (o_received_crc),
        .o_values_reply    (o_values_reply),
        .o_payload_valid   (o_payload_valid),
        .o_payload_byte    (o_payload_byte),
        .o_ok_count        (o_ok_count),
        .o_crc_fail_count  (o_crc_fail_count),
        .o_end_fail_count  (o_end_fail_count),
        .o_values_ok_count (o_values_ok_count)
    );

    assign seen = {o_frame_status, o_frame_length, o_command_byte, o_computed_crc,
                   o_received_crc, o_values_reply, o_payload_valid, o_payload_byte,
                   o_ok_count, o_crc_fail_count, o_end_fail_count, o_values_ok_count};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: take a beat when offered, then pick the next ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            shadow.check_report(seen);
        end
        i_res_ready <= ($urandom_range(99) >= res_stall);
    end

    // Offer one rx beat, after a random gap; valid stays high between beats
    // when no gap is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) begin
            @(posedge i_clk);
        end
        if (shadow.take_byte(b)) begin
            bytes_sent++;
        end
    endtask

    task automatic send_frame(input bit long_hdr, input logic [15:0] len,
                              input logic [7:0] lead, input frame_flaw_e flaw);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = '0;
        if (long_hdr) begin
            send_byte(START_LONG);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else begin
            send_byte(START_SHORT);
            send_byte(len[7:0]);
        end
        // rejected lengths end right after the header
        if (len == 0 || len > MAX_LEN) begin
            return;
        end
        for (int k = 0; k < len; k++) begin
            b   = (k == 0) ? lead : 8'($urandom_range(255));
            crc = crc16_bitwise(crc, b);
            send_byte(b);
        end
        if (flaw == FLAW_CRC || (flaw == FLAW_STOP && $urandom_range(1) == 1)) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        if (flaw == FLAW_STOP) begin
            do begin
                b = 8'($urandom_range(255));
            end while (b == STOP_BYTE);
            send_byte(b);
        end else begin
            send_byte(STOP_BYTE);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        shadow.set_register(idx, val);
    endtask

    task automatic configure(input logic [7:0] full_op, input logic [7:0] sel_op);
        write_reg(CFG_VALUES_OPCODE, full_op);
        write_reg(CFG_SEL_OPCODE, sel_op);
        // unused index: must leave both opcodes alone
        write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(255)));
        i_cfg_valid <= 1'b0;
        op_full = full_op;
        op_sel  = sel_op;
    endtask

    initial begin
        logic [15:0] len;
        logic [7:0]  lead;
        frame_flaw_e flaw;
        bit          long_hdr;
        int          roll;
        int          target;

        shadow      = new();
        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_res_ready = 1'b1;
        send_idle   = 0;
        res_stall   = 0;
        bytes_sent  = 0;
        op_full     = 8'd4;
        op_sel      = 8'd50;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, opcodes still at their reset values
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(1'b0, 16'd1, op_full, FLAW_NONE);
        send_frame(1'b0, 16'd0, 8'h00, FLAW_NONE);
        send_frame(1'b1, 16'(MAX_LEN + 1), 8'h00, FLAW_NONE);
        send_frame(1'b1, 16'd1, op_sel, FLAW_CRC);
        send_frame(1'b0, 16'd1, 8'hAA, FLAW_STOP);
        i_rx_valid <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            // opcodes change only with the pipe empty
            while (shadow.pending() != 0) begin
                @(posedge i_clk);
            end
            repeat (2) @(posedge i_clk);
            case (ph)
                0: configure(8'h00, 8'hFF);
                1: configure(8'hFF, 8'h00);
                2: configure(8'($urandom_range(255)), 8'($urandom_range(255)));
                default: begin
                    lead = 8'($urandom_range(255));
                    configure(lead, lead);
                end
            endcase
            send_idle = (ph == 1) ? 65 : (ph == 3) ? 15 : 0;
            res_stall = (ph == 2) ? 65 : (ph == 3) ? 15 : 0;
            target    = bytes_sent + ((ph == 0) ? 560 : 190);
            if (ph == 0) begin
                send_frame(1'b1, 16'(MAX_LEN), op_full, FLAW_NONE);
            end
            while (bytes_sent < target) begin
                roll = $urandom_range(99);
                if (roll < 6) begin
                    // line noise, may also open a frame by chance
                    send_byte(8'($urandom_range(255)));
                end else if (roll < 11) begin
                    if ($urandom_range(1) == 1) begin
                        send_frame(1'($urandom_range(1)), 16'd0, 8'h00, FLAW_NONE);
                    end else begin
                        send_frame(1'b1, 16'($urandom_range(MAX_LEN + 1, 65535)), 8'h00,
                                   FLAW_NONE);
                    end
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 85) begin
                        len = 16'($urandom_range(1, 8));
                    end else if (roll < 97) begin
                        len = 16'($urandom_range(9, 64));
                    end else begin
                        len = 16'($urandom_range(250, 260));
                    end
                    long_hdr = (len > 255) || ($urandom_range(3) == 0);
                    roll     = $urandom_range(99);
                    lead     = (roll < 35) ? op_full :
                               (roll < 50) ? op_sel : 8'($urandom_range(255));
                    roll     = $urandom_range(99);
                    flaw     = (roll < 78) ? FLAW_NONE : (roll < 89) ? FLAW_CRC : FLAW_STOP;
                    send_frame(long_hdr, len, lead, flaw);
                end
            end
            i_rx_valid <= 1'b0;
        end

        while (shadow.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (shadow.mismatches == 0) begin
            $display("tb_crc_checked_packet_deframer: clean");
        end else begin
            $display("tb_crc_checked_packet_deframer: errors");
        end
        $finish;
    end

    // about 1200 beats in all; a 2 ms timeout is far beyond what they need
    initial begin
        #2_000_000;
        $display("tb_crc_checked_packet_deframer: errors");
        $finish;
    end

endmodule
